>>> rtl/core/csb_pkg.sv
// Shared constants, request types and key helpers for the counting sort batch block.
package csb_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int KEY_BITS   = 8;
    localparam int KEY_RANGE  = 1 << KEY_BITS;
    localparam int IN_KEY_W   = 8;
    localparam int OUT_KEY_W  = 8;
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int PTR_BITS   = KEY_BITS + 1;

    typedef struct packed {
        logic                rd_en;
        logic [KEY_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [KEY_BITS-1:0] wr_addr;
        logic [CNT_BITS-1:0] wr_data;
        logic                clear;
    } cnt_req_t;

    function automatic logic [KEY_BITS-1:0] mask_key(input logic [IN_KEY_W-1:0] k);
        logic [KEY_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < KEY_BITS; b++) begin
            if (b < IN_KEY_W) begin
                r[b] = k[b];
            end
        end
        return r;
    endfunction

    function automatic logic [OUT_KEY_W-1:0] key_to_out(input logic [KEY_BITS-1:0] k);
        logic [OUT_KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < OUT_KEY_W; b++) begin
            if (b < KEY_BITS) begin
                r[b] = k[b];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/counting_sort_batch.sv
// Top level of the counting sort batch block: sequencer, count store and key buffers.
//
// Input channel s_: one key per transfer, s_last_item marks the end of a batch.
// Keys are masked to KEY_BITS bits; up to MAX_ITEMS keys are held, later keys
// of the batch are dropped and every result of that batch carries m_dropped.
// Output channel m_: the held keys in ascending order, m_last_result on the
// final one. Nothing comes out for a key that does not end a batch.
// Each held key costs a read-modify-write on the count store (s_ready is
// low during the write back). The final key then starts a prefix pass over
// every count store entry, a scatter of each held key (key buffer read,
// count read, write back) and an emit of each key through the sorted
// buffer's read port.
// s_ready stays low from the final key until the last result is loaded into
// the output register; a stall on m_ready holds that register and the emit
// pass. The last result may wait while the next batch is already loading.
// Reset is synchronous (aresetn low): counts read as zero at once through
// per-entry valid bits, so no clearing pass follows reset or a batch.
module counting_sort_batch
    import csb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_KEY_W-1:0]  s_key,
    input  logic                 s_last_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_KEY_W-1:0] m_sorted_key,
    output logic                 m_last_result,
    output logic                 m_dropped
);

    cnt_req_t            cnt_req;
    logic [CNT_BITS-1:0] cnt_rd_data;
    logic                kb_we, kb_re, sb_we, sb_re;
    logic [IDX_BITS-1:0] kb_waddr, kb_raddr, sb_waddr, sb_raddr;
    logic [KEY_BITS-1:0] kb_wdata, kb_rdata, sb_wdata, sb_rdata;

    csb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_key  (m_sorted_key),
        .m_last_result (m_last_result),
        .m_dropped     (m_dropped),
        .cnt_req       (cnt_req),
        .cnt_rd_data   (cnt_rd_data),
        .kb_we         (kb_we),
        .kb_waddr      (kb_waddr),
        .kb_wdata      (kb_wdata),
        .kb_re         (kb_re),
        .kb_raddr      (kb_raddr),
        .kb_rdata      (kb_rdata),
        .sb_we         (sb_we),
        .sb_waddr      (sb_waddr),
        .sb_wdata      (sb_wdata),
        .sb_re         (sb_re),
        .sb_raddr      (sb_raddr),
        .sb_rdata      (sb_rdata)
    );

    csb_count_store u_count_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cnt_req),
        .rd_data (cnt_rd_data)
    );

    csb_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (KEY_BITS)
    ) u_key_buffer (
        .aclk  (aclk),
        .we    (kb_we),
        .waddr (kb_waddr),
        .wdata (kb_wdata),
        .re    (kb_re),
        .raddr (kb_raddr),
        .rdata (kb_rdata)
    );

    csb_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (KEY_BITS)
    ) u_sorted_buffer (
        .aclk  (aclk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .re    (sb_re),
        .raddr (sb_raddr),
        .rdata (sb_rdata)
    );

endmodule

>>> rtl/core/csb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module csb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/csb_count_store.sv
// Per-key occurrence count store with flip-flop valid bits that clear every entry at once.
module csb_count_store
    import csb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cnt_req_t            req,
    output logic [CNT_BITS-1:0] rd_data
);

    logic [KEY_RANGE-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [CNT_BITS-1:0]  ram_q;

    csb_ram #(
        .DEPTH (KEY_RANGE),
        .WIDTH (CNT_BITS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

>>> rtl/core/csb_ctrl.sv
// Sequencer and shared adder: load, prefix, scatter and emit passes plus the result register.
module csb_ctrl
    import csb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_KEY_W-1:0]  s_key,
    input  logic                 s_last_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_KEY_W-1:0] m_sorted_key,
    output logic                 m_last_result,
    output logic                 m_dropped,
    output cnt_req_t             cnt_req,
    input  logic [CNT_BITS-1:0]  cnt_rd_data,
    output logic                 kb_we,
    output logic [IDX_BITS-1:0]  kb_waddr,
    output logic [KEY_BITS-1:0]  kb_wdata,
    output logic                 kb_re,
    output logic [IDX_BITS-1:0]  kb_raddr,
    input  logic [KEY_BITS-1:0]  kb_rdata,
    output logic                 sb_we,
    output logic [IDX_BITS-1:0]  sb_waddr,
    output logic [KEY_BITS-1:0]  sb_wdata,
    output logic                 sb_re,
    output logic [IDX_BITS-1:0]  sb_raddr,
    input  logic [KEY_BITS-1:0]  sb_rdata
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_INC    = 8'b0000_0010,
        ST_PREFIX = 8'b0000_0100,
        ST_SC_RDK = 8'b0000_1000,
        ST_SC_RDC = 8'b0001_0000,
        ST_SC_WR  = 8'b0010_0000,
        ST_EM_RD  = 8'b0100_0000,
        ST_EM_OUT = 8'b1000_0000
    } csb_state_t;

    csb_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]  held_reg, held_next;
    logic                 overflow_reg, overflow_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 last_reg, last_next;
    logic [PTR_BITS-1:0]  ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]  running_reg, running_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_KEY_W-1:0] m_key_reg, m_key_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_dropped_reg, m_dropped_next;

    logic [CNT_BITS-1:0]  alu_a, alu_b, alu_sum;
    logic [PTR_BITS-1:0]  ptr_prev;
    logic [KEY_BITS-1:0]  s_key_m;
    logic                 s_fire;
    logic                 slot_free;
    logic                 idx_is_last;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign s_key_m     = mask_key(s_key);
    assign ptr_prev    = ptr_reg - PTR_BITS'(1);
    assign slot_free   = !m_valid_reg || m_ready;
    assign idx_is_last = ((idx_reg + CNT_BITS'(1)) == held_reg);

    // Shared adder: increment on load, accumulate on prefix, decrement on scatter.
    always_comb begin
        case (state_reg)
            ST_INC: begin
                alu_a = cnt_rd_data;
                alu_b = CNT_BITS'(1);
            end
            ST_PREFIX: begin
                alu_a = running_reg;
                alu_b = cnt_rd_data;
            end
            ST_SC_WR: begin
                alu_a = cnt_rd_data;
                alu_b = '1;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end
    assign alu_sum = alu_a + alu_b;

    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        overflow_next  = overflow_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        ptr_next       = ptr_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_key_next     = m_key_reg;
        m_last_next    = m_last_reg;
        m_dropped_next = m_dropped_reg;

        cnt_req        = '0;
        kb_we          = 1'b0;
        kb_waddr       = held_reg[IDX_BITS-1:0];
        kb_wdata       = s_key_m;
        kb_re          = 1'b0;
        kb_raddr       = idx_reg[IDX_BITS-1:0];
        sb_we          = 1'b0;
        sb_waddr       = alu_sum[IDX_BITS-1:0];
        sb_wdata       = kb_rdata;
        sb_re          = 1'b0;
        sb_raddr       = idx_reg[IDX_BITS-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (held_reg < CNT_BITS'(MAX_ITEMS)) begin
                        kb_we           = 1'b1;
                        cnt_req.rd_en   = 1'b1;
                        cnt_req.rd_addr = s_key_m;
                        key_next        = s_key_m;
                        last_next       = s_last_item;
                        held_next       = held_reg + CNT_BITS'(1);
                        state_next      = ST_INC;
                    end else begin
                        // Buffer full: drop the key but still honor the batch end.
                        overflow_next = 1'b1;
                        if (s_last_item) begin
                            ptr_next     = '0;
                            running_next = '0;
                            state_next   = ST_PREFIX;
                        end
                    end
                end
            end
            ST_INC: begin
                cnt_req.wr_en   = 1'b1;
                cnt_req.wr_addr = key_reg;
                cnt_req.wr_data = alu_sum;
                if (last_reg) begin
                    ptr_next     = '0;
                    running_next = '0;
                    state_next   = ST_PREFIX;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREFIX: begin
                // Read entry ptr while writing the running sum of entry ptr-1.
                if (ptr_reg != PTR_BITS'(KEY_RANGE)) begin
                    cnt_req.rd_en   = 1'b1;
                    cnt_req.rd_addr = ptr_reg[KEY_BITS-1:0];
                end
                if (ptr_reg != '0) begin
                    cnt_req.wr_en   = 1'b1;
                    cnt_req.wr_addr = ptr_prev[KEY_BITS-1:0];
                    cnt_req.wr_data = alu_sum;
                    running_next    = alu_sum;
                end
                ptr_next = ptr_reg + PTR_BITS'(1);
                if (ptr_reg == PTR_BITS'(KEY_RANGE)) begin
                    idx_next   = '0;
                    state_next = ST_SC_RDK;
                end
            end
            ST_SC_RDK: begin
                kb_re      = 1'b1;
                state_next = ST_SC_RDC;
            end
            ST_SC_RDC: begin
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = kb_rdata;
                state_next      = ST_SC_WR;
            end
            ST_SC_WR: begin
                sb_we           = 1'b1;
                cnt_req.wr_en   = 1'b1;
                cnt_req.wr_addr = kb_rdata;
                cnt_req.wr_data = alu_sum;
                idx_next        = idx_reg + CNT_BITS'(1);
                if (idx_is_last) begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end else begin
                    state_next = ST_SC_RDK;
                end
            end
            ST_EM_RD: begin
                sb_re      = 1'b1;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_key_next     = key_to_out(sb_rdata);
                    m_last_next    = idx_is_last;
                    m_dropped_next = overflow_reg;
                    idx_next       = idx_reg + CNT_BITS'(1);
                    if (idx_is_last) begin
                        // Final result loaded: reset batch state and take new keys.
                        cnt_req.clear = 1'b1;
                        held_next     = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_reg     <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        last_reg      <= last_next;
        ptr_reg       <= ptr_next;
        running_reg   <= running_next;
        idx_reg       <= idx_next;
        m_key_reg     <= m_key_next;
        m_last_reg    <= m_last_next;
        m_dropped_reg <= m_dropped_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_sorted_key  = m_key_reg;
    assign m_last_result = m_last_reg;
    assign m_dropped     = m_dropped_reg;

endmodule

>>> tb/tb_counting_sort_batch.sv
// Self-checking testbench for the counting sort batch block: random batches, stalls, overflow.
module tb_counting_sort_batch
    import csb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IN_KEY_W-1:0] key;
        logic                last;
        logic                wait_drain;
    } key_beat_t;

    typedef struct packed {
        logic [OUT_KEY_W-1:0] key;
        logic                 last;
        logic                 dropped;
    } sorted_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IN_KEY_W-1:0]  s_key = '0;
    logic                 s_last_item = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_KEY_W-1:0] m_sorted_key;
    logic                 m_last_result;
    logic                 m_dropped;

    key_beat_t      pending_keys[$];
    sorted_result_t sorted_due[$];
    key_beat_t      next_beat;

    // Shadow of the batch being loaded
    logic [KEY_BITS-1:0] held_keys[MAX_ITEMS];
    int                  held_count = 0;
    logic                overflow_seen = 1'b0;

    int  keys_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  rx_hold_left = 0;
    bit  rx_hold_done = 1'b0;
    bit  tx_idle;
    int  queued_total = 0;

    counting_sort_batch DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_key  (m_sorted_key),
        .m_last_result (m_last_result),
        .m_dropped     (m_dropped)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Hold the key if there is room, else flag overflow; on the batch end, sort the held keys by tallying each value.
    task automatic absorb_key(input logic [IN_KEY_W-1:0] raw, input logic last);
        int             tally[KEY_RANGE];
        int             emitted;
        sorted_result_t res;
        if (held_count < MAX_ITEMS) begin
            held_keys[held_count] = raw[KEY_BITS-1:0];
            held_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            for (int v = 0; v < KEY_RANGE; v++) begin
                tally[v] = 0;
            end
            for (int i = 0; i < held_count; i++) begin
                tally[held_keys[i]]++;
            end
            emitted = 0;
            for (int v = 0; v < KEY_RANGE; v++) begin
                for (int c = 0; c < tally[v]; c++) begin
                    emitted++;
                    res.key = OUT_KEY_W'(v);
                    res.last = (emitted == held_count);
                    res.dropped = overflow_seen;
                    sorted_due.push_back(res);
                end
            end
            held_count = 0;
            overflow_seen = 1'b0;
        end
    endtask

    task automatic check_result();
        sorted_result_t want;
        if (sorted_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result key=%0d last=%0d dropped=%0d",
                                      m_sorted_key, m_last_result, m_dropped));
        end else begin
            want = sorted_due.pop_front();
            if (m_sorted_key !== want.key) begin
                report_mismatch($sformatf("result %0d: sorted_key %0d, expected %0d",
                                          results_seen, m_sorted_key, want.key));
            end
            if (m_last_result !== want.last) begin
                report_mismatch($sformatf("result %0d: last_result %0d, expected %0d",
                                          results_seen, m_last_result, want.last));
            end
            if (m_dropped !== want.dropped) begin
                report_mismatch($sformatf("result %0d: dropped %0d, expected %0d",
                                          results_seen, m_dropped, want.dropped));
            end
        end
        results_seen++;
    endtask

    // Sender: present the next queued key once the previous transfer is done, with random idle gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_key(s_key, s_last_item);
                keys_sent++;
            end
            if (!s_valid || s_ready) begin
                tx_idle = (keys_sent >= 200 && keys_sent < 300) ? 1'b0
                          : ($urandom_range(0, 99) < 37);
                if (pending_keys.size() > 0 && !tx_idle &&
                    (!pending_keys[0].wait_drain || sorted_due.size() == 0)) begin
                    next_beat = pending_keys.pop_front();
                    s_key <= next_beat.key;
                    s_last_item <= next_beat.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each transfer, then pick m_ready for the next cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_ready <= 1'b0;
            end else if (!rx_hold_done && results_seen >= 150) begin
                // long hold-off so the block backs up and stalls its input
                rx_hold_done <= 1'b1;
                rx_hold_left <= 600;
                m_ready <= 1'b0;
            end else if (results_seen >= 300 && results_seen < 450) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 37);
            end
        end
    end

    task automatic push_key(input int k, input bit last, input bit drain);
        key_beat_t beat;
        beat.key = IN_KEY_W'(k);
        beat.last = last;
        beat.wait_drain = drain;
        pending_keys.push_back(beat);
        queued_total++;
    endtask

    task automatic queue_batch(input int n, input int base, input int span, input bit drain);
        for (int i = 0; i < n; i++) begin
            push_key((base + $urandom_range(0, span)) & 8'hFF, i == n - 1, drain && i == 0);
        end
    endtask

    initial begin
        int shape;
        int n;
        int span;
        int batch_no;

        // Single-key batches at both ends of the key range
        push_key(0, 1'b1, 1'b0);
        push_key(255, 1'b1, 1'b0);
        // Extremes with a repeated key
        push_key(255, 1'b0, 1'b0);
        push_key(0, 1'b0, 1'b0);
        push_key(128, 1'b0, 1'b0);
        push_key(0, 1'b1, 1'b0);
        // Descending powers of two
        for (int b = 7; b >= 0; b--) begin
            push_key(1 << b, b == 0, 1'b0);
        end
        // All keys equal, sent once all earlier results have been received
        push_key(7, 1'b0, 1'b1);
        push_key(7, 1'b0, 1'b0);
        push_key(7, 1'b1, 1'b0);

        batch_no = 0;
        while (queued_total < 480) begin
            shape = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: span = 0;
                1: span = 3;
                default: span = 255;
            endcase
            if (shape < 70) begin
                n = $urandom_range(1, 12);
            end else if (shape < 85) begin
                n = $urandom_range(13, MAX_ITEMS - 1);
            end else if (shape < 92) begin
                n = MAX_ITEMS;
            end else begin
                // overflow: the final key itself lands on a full buffer
                n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            end
            if (batch_no == 3) begin
                n = MAX_ITEMS + 2;
            end
            queue_batch(n, $urandom_range(0, 255), span,
                        batch_no == 0 || $urandom_range(0, 9) == 0);
            batch_no++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_keys.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        while (sorted_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (800) @(posedge aclk);

        if (sorted_due.size() > 0) begin
            report_mismatch($sformatf("%0d results never arrived", sorted_due.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/csb_pkg.sv
rtl/core/csb_ram.sv
rtl/core/csb_count_store.sv
rtl/core/csb_ctrl.sv
rtl/core/counting_sort_batch.sv
tb/tb_counting_sort_batch.sv
